@@ rtl/core/epat_pkg.sv @@
// ----------------------------------------------------------------------------
// Encoder PLL angle tracker package
// Shared widths, reset values, codes and the microprogram ROM of the tracker.
// ----------------------------------------------------------------------------
package epat_pkg;

   // Widths
   localparam int COUNT_BITS_DEFAULT = 14;
   localparam int CSR_DATA_W         = 32;
   localparam int CSR_INDEX_W        = 3;
   localparam int INTERVAL_W         = 24;
   localparam int MUL_W              = 33;
   localparam int PROD_W             = 2 * MUL_W;
   localparam int ACC_W              = 50;
   localparam int K_W                = 30;
   localparam int STEP_W             = 4;

   // Register reset values
   localparam logic [31:0]           KP_RESET           = 32'd13107200;
   localparam logic [31:0]           KI_RESET           = 32'd10240000;
   localparam logic [INTERVAL_W-1:0] MAX_INTERVAL_RESET = 24'd16777;
   localparam logic [30:0]           GLITCH_RESET       = 31'd429496730;
   localparam logic [6:0]            POLE_PAIRS_RESET   = 7'd7;

   // Two pi in Q3.20
   localparam logic [22:0] TWO_PI_Q20 = 23'd6588397;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KP_GAIN      = 3'd0,
      CSR_KI_GAIN      = 3'd1,
      CSR_MAX_INTERVAL = 3'd2,
      CSR_GLITCH       = 3'd3,
      CSR_POLE_PAIRS   = 3'd4,
      CSR_DIRECTION    = 3'd5,
      CSR_ELEC_OFFSET  = 3'd6
   } csr_index_type;

   // Update causes
   typedef enum logic [1:0] {
      CAUSE_TRACKED  = 2'd0,
      CAUSE_INTERVAL = 2'd1,
      CAUSE_SEED     = 2'd2,
      CAUSE_GLITCH   = 2'd3
   } cause_type;

   // Multiplier operand selects
   typedef enum logic [3:0] {
      A_KP, A_KI, A_RH, A_RL, A_P0, A_P1, A_P2, A_PP, A_POS, A_VEL
   } mul_a_type;

   typedef enum logic [2:0] {
      B_ERR, B_DT, B_PP, B_TWOPI, B_K
   } mul_b_type;

   // Datapath operations
   typedef enum logic [3:0] {
      OP_NOP, OP_LOAD, OP_CHECK, OP_RATE, OP_SAVE_P, OP_POS_HI, OP_POS_LO,
      OP_T0, OP_T1, OP_NV, OP_SAT, OP_K, OP_ANG, OP_EVEL, OP_OUT
   } op_type;

   // Sequencer jump conditions
   typedef enum logic [1:0] {
      JC_NONE,      // fall through
      JC_WAIT_REQ,  // hold until a request beat, then jump
      JC_RESEED,    // jump when the sample re-seeds the estimate
      JC_WAIT_OUT   // hold until the result register is free, then jump
   } jump_type;

   // Jump targets
   localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
   localparam logic [STEP_W-1:0] STEP_CHECK = 4'd1;
   localparam logic [STEP_W-1:0] STEP_ELEC  = 4'd11;
   localparam logic [STEP_W-1:0] STEP_OUT   = 4'd15;

   typedef struct packed {
      mul_a_type         mul_a;
      mul_b_type         mul_b;
      op_type            op;
      jump_type          jump;
      logic [STEP_W-1:0] target;
   } ctrl_word_type;

   function automatic ctrl_word_type cw_make(input mul_a_type a, input mul_b_type b,
                                             input op_type o, input jump_type j,
                                             input logic [STEP_W-1:0] t);
      ctrl_word_type w;
      w.mul_a  = a;
      w.mul_b  = b;
      w.op     = o;
      w.jump   = j;
      w.target = t;
      return w;
   endfunction

   // Microprogram: the multiply issued in one step is consumed in the next
   function automatic ctrl_word_type ucode(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      unique case (step)
         4'd0:    w = cw_make(A_KP,  B_ERR,   OP_LOAD,   JC_WAIT_REQ, STEP_CHECK);
         4'd1:    w = cw_make(A_KP,  B_ERR,   OP_CHECK,  JC_RESEED,   STEP_ELEC);
         4'd2:    w = cw_make(A_KP,  B_ERR,   OP_NOP,    JC_NONE,     STEP_IDLE);
         4'd3:    w = cw_make(A_KI,  B_ERR,   OP_RATE,   JC_NONE,     STEP_IDLE);
         4'd4:    w = cw_make(A_RH,  B_DT,    OP_SAVE_P, JC_NONE,     STEP_IDLE);
         4'd5:    w = cw_make(A_RL,  B_DT,    OP_POS_HI, JC_NONE,     STEP_IDLE);
         4'd6:    w = cw_make(A_P0,  B_DT,    OP_POS_LO, JC_NONE,     STEP_IDLE);
         4'd7:    w = cw_make(A_P1,  B_DT,    OP_T0,     JC_NONE,     STEP_IDLE);
         4'd8:    w = cw_make(A_P2,  B_DT,    OP_T1,     JC_NONE,     STEP_IDLE);
         4'd9:    w = cw_make(A_PP,  B_TWOPI, OP_NV,     JC_NONE,     STEP_IDLE);
         4'd10:   w = cw_make(A_PP,  B_TWOPI, OP_SAT,    JC_NONE,     STEP_IDLE);
         4'd11:   w = cw_make(A_PP,  B_TWOPI, OP_NOP,    JC_NONE,     STEP_IDLE);
         4'd12:   w = cw_make(A_POS, B_PP,    OP_K,      JC_NONE,     STEP_IDLE);
         4'd13:   w = cw_make(A_VEL, B_K,     OP_ANG,    JC_NONE,     STEP_IDLE);
         4'd14:   w = cw_make(A_VEL, B_K,     OP_EVEL,   JC_NONE,     STEP_IDLE);
         default: w = cw_make(A_VEL, B_K,     OP_OUT,    JC_WAIT_OUT, STEP_IDLE);
      endcase
      return w;
   endfunction

endpackage

@@ rtl/core/encoder_pll_angle_tracker_top.sv @@
// ----------------------------------------------------------------------------
// Encoder PLL angle tracker: microcoded second-order observer, one multiplier
// A request beat is taken only in the idle step; the input stalls until the program returns there.
// Work per sample is set by the 16-step microprogram; a re-seed skips the tracking steps,
// and every product runs through one shared 33x33 multiplier.
// Reset: synchronous; registers to defaults, estimate cleared and not seeded.
// ----------------------------------------------------------------------------
module encoder_pll_angle_tracker_top
   import epat_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    csr_write_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [COUNT_BITS-1:0]   req_raw_count,
   input  logic [INTERVAL_W-1:0]   req_interval,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [31:0]      rsp_mech_position,
   output logic signed [31:0]      rsp_mech_velocity,
   output logic signed [15:0]      rsp_elec_angle,
   output logic signed [47:0]      rsp_elec_velocity,
   output logic [1:0]              rsp_update_cause
);

   // Sequencer
   logic [STEP_W-1:0] pc_ff, pc_in;
   ctrl_word_type     cw;

   // Configuration registers
   logic [31:0]           kp_ff, kp_in;
   logic [31:0]           ki_ff, ki_in;
   logic [INTERVAL_W-1:0] max_int_ff, max_int_in;
   logic [30:0]           thr_ff, thr_in;
   logic [6:0]            pp_ff, pp_in;
   logic                  dir_ff, dir_in;
   logic [15:0]           offs_ff, offs_in;

   // Observer state
   logic [31:0]        pos_ff, pos_in;
   logic signed [31:0] vel_ff, vel_in;
   logic               seeded_ff, seeded_in;

   // Working registers
   logic [31:0]              meas_ff, meas_in;
   logic [INTERVAL_W-1:0]    dt_ff, dt_in;
   logic signed [31:0]       err_ff, err_in;
   cause_type                cause_ff, cause_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [63:0]       p_ff, p_in;
   logic [K_W-1:0]           k_ff, k_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [15:0]              ang_ff, ang_in;
   logic [47:0]              ev_ff, ev_in;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_pos_ff, rsp_pos_in;
   logic [31:0] rsp_vel_ff, rsp_vel_in;
   logic [15:0] rsp_ang_ff, rsp_ang_in;
   logic [47:0] rsp_ev_ff, rsp_ev_in;
   cause_type   rsp_cause_ff, rsp_cause_in;

   // Combinational helpers
   logic                     accept;
   logic                     out_free;
   logic                     out_load;
   logic [31:0]              err_now;
   logic [31:0]              err_mag;
   logic                     interval_bad;
   logic                     glitch;
   logic                     reseed_now;
   cause_type                cause_now;
   logic signed [MUL_W-1:0]  a_op;
   logic signed [MUL_W-1:0]  b_op;
   logic                     sat_hi;
   logic                     sat_lo;
   logic [31:0]              e_dir;
   logic signed [PROD_W-1:0] ev_round;
   logic [47:0]              ev_dir;

   assign cw        = ucode(pc_ff);
   assign req_stall = (pc_ff != STEP_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign out_load  = (cw.op == OP_OUT) && out_free;

   // Classify the sample against the current estimate
   assign err_now      = meas_ff - pos_ff;
   assign err_mag      = err_now[31] ? (32'd0 - err_now) : err_now;
   assign interval_bad = (dt_ff == '0) || (dt_ff > max_int_ff);
   assign glitch       = err_mag > {1'b0, thr_ff};
   assign reseed_now   = interval_bad || !seeded_ff || glitch;

   always_comb begin
      priority if (interval_bad) begin
         cause_now = CAUSE_INTERVAL;
      end else if (!seeded_ff) begin
         cause_now = CAUSE_SEED;
      end else if (glitch) begin
         cause_now = CAUSE_GLITCH;
      end else begin
         cause_now = CAUSE_TRACKED;
      end
   end

   // Select multiplier operands
   always_comb begin
      unique case (cw.mul_a)
         A_KP:    a_op = {1'b0, kp_ff};
         A_KI:    a_op = {1'b0, ki_ff};
         A_RH:    a_op = {{7{acc_ff[ACC_W-1]}}, acc_ff[ACC_W-1:24]};
         A_RL:    a_op = {9'b0, acc_ff[23:0]};
         A_P0:    a_op = {9'b0, p_ff[23:0]};
         A_P1:    a_op = {9'b0, p_ff[47:24]};
         A_P2:    a_op = {{17{p_ff[63]}}, p_ff[63:48]};
         A_PP:    a_op = {26'b0, pp_ff};
         A_POS:   a_op = {1'b0, pos_ff};
         A_VEL:   a_op = {vel_ff[31], vel_ff};
         default: a_op = '0;
      endcase
      unique case (cw.mul_b)
         B_ERR:   b_op = {err_ff[31], err_ff};
         B_DT:    b_op = {9'b0, dt_ff};
         B_PP:    b_op = {26'b0, pp_ff};
         B_TWOPI: b_op = {10'b0, TWO_PI_Q20};
         B_K:     b_op = {3'b0, k_ff};
         default: b_op = '0;
      endcase
   end

   assign prod_in = a_op * b_op;

   // Saturation and electrical terms
   assign sat_hi   = !acc_ff[ACC_W-1] && (acc_ff[ACC_W-2:31] != '0);
   assign sat_lo   = acc_ff[ACC_W-1] && (acc_ff[ACC_W-2:31] != '1);
   assign e_dir    = dir_ff ? (32'd0 - prod_ff[31:0]) : prod_ff[31:0];
   assign ev_round = (prod_ff + $signed(PROD_W'(8))) >>> 4;
   assign ev_dir   = dir_ff ? (48'd0 - ev_round[47:0]) : ev_round[47:0];

   // Next program step
   always_comb begin
      unique case (cw.jump)
         JC_NONE:     pc_in = pc_ff + STEP_W'(1);
         JC_WAIT_REQ: pc_in = req_valid ? cw.target : pc_ff;
         JC_RESEED:   pc_in = reseed_now ? cw.target : pc_ff + STEP_W'(1);
         JC_WAIT_OUT: pc_in = out_free ? cw.target : pc_ff;
         default:     pc_in = STEP_IDLE;
      endcase
   end

   // Datapath operations and register writes
   always_comb begin
      kp_in      = kp_ff;
      ki_in      = ki_ff;
      max_int_in = max_int_ff;
      thr_in     = thr_ff;
      pp_in      = pp_ff;
      dir_in     = dir_ff;
      offs_in    = offs_ff;
      pos_in     = pos_ff;
      vel_in     = vel_ff;
      seeded_in  = seeded_ff;
      meas_in    = meas_ff;
      dt_in      = dt_ff;
      err_in     = err_ff;
      cause_in   = cause_ff;
      acc_in     = acc_ff;
      p_in       = p_ff;
      k_in       = k_ff;
      ang_in     = ang_ff;
      ev_in      = ev_ff;

      // configuration write
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_KP_GAIN:      kp_in      = csr_wdata;
            CSR_KI_GAIN:      ki_in      = csr_wdata;
            CSR_MAX_INTERVAL: max_int_in = csr_wdata[INTERVAL_W-1:0];
            CSR_GLITCH:       thr_in     = csr_wdata[30:0];
            CSR_POLE_PAIRS:   pp_in      = csr_wdata[6:0];
            CSR_DIRECTION:    dir_in     = csr_wdata[0];
            CSR_ELEC_OFFSET:  offs_in    = csr_wdata[15:0];
            default: ;
         endcase
      end

      unique case (cw.op)
         OP_LOAD: begin
            if (accept) begin
               meas_in = {req_raw_count, {(32 - COUNT_BITS){1'b0}}};
               dt_in   = req_interval;
            end
         end
         OP_CHECK: begin
            err_in   = err_now;
            cause_in = cause_now;
            if (reseed_now) begin
               pos_in    = meas_ff;
               vel_in    = '0;
               seeded_in = 1'b1;
            end
         end
         // rate = vel * 2^16 + floor(kp * err / 2^16), Q.32 rev/s
         OP_RATE:   acc_in = {{2{vel_ff[31]}}, vel_ff, 16'b0} + prod_ff[PROD_W-1:16];
         OP_SAVE_P: p_in   = prod_ff[63:0];
         OP_POS_HI: pos_in = pos_ff + prod_ff[31:0];
         OP_POS_LO: pos_in = pos_ff + {8'b0, prod_ff[47:24]};
         OP_T0:     acc_in = {26'b0, prod_ff[47:24]};
         OP_T1:     acc_in = acc_ff + {2'b0, prod_ff[47:0]};
         // vel + floor(ki * err * dt / 2^48)
         OP_NV: begin
            acc_in = {{18{vel_ff[31]}}, vel_ff} + prod_ff[ACC_W-1:0]
                     + {24'b0, acc_ff[ACC_W-1:24]};
         end
         OP_SAT: begin
            if (sat_hi) begin
               vel_in = 32'sh7fffffff;
            end else if (sat_lo) begin
               vel_in = 32'sh80000000;
            end else begin
               vel_in = acc_ff[31:0];
            end
         end
         OP_K:    k_in   = prod_ff[K_W-1:0];
         OP_ANG:  ang_in = e_dir[31:16] + offs_ff;
         OP_EVEL: ev_in  = ev_dir;
         default: ;
      endcase
   end

   // Result register
   always_comb begin
      rsp_pos_in   = rsp_pos_ff;
      rsp_vel_in   = rsp_vel_ff;
      rsp_ang_in   = rsp_ang_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_cause_in = rsp_cause_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = pos_ff;
         rsp_vel_in   = vel_ff;
         rsp_ang_in   = ang_ff;
         rsp_ev_in    = ev_ff;
         rsp_cause_in = cause_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // Control, configuration and observer state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         kp_ff        <= KP_RESET;
         ki_ff        <= KI_RESET;
         max_int_ff   <= MAX_INTERVAL_RESET;
         thr_ff       <= GLITCH_RESET;
         pp_ff        <= POLE_PAIRS_RESET;
         dir_ff       <= 1'b0;
         offs_ff      <= '0;
         pos_ff       <= '0;
         vel_ff       <= '0;
         seeded_ff    <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         max_int_ff   <= max_int_in;
         thr_ff       <= thr_in;
         pp_ff        <= pp_in;
         dir_ff       <= dir_in;
         offs_ff      <= offs_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         seeded_ff    <= seeded_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      meas_ff      <= meas_in;
      dt_ff        <= dt_in;
      err_ff       <= err_in;
      cause_ff     <= cause_in;
      acc_ff       <= acc_in;
      p_ff         <= p_in;
      k_ff         <= k_in;
      prod_ff      <= prod_in;
      ang_ff       <= ang_in;
      ev_ff        <= ev_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_vel_ff   <= rsp_vel_in;
      rsp_ang_ff   <= rsp_ang_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_cause_ff <= rsp_cause_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mech_position = rsp_pos_ff;
   assign rsp_mech_velocity = rsp_vel_ff;
   assign rsp_elec_angle    = rsp_ang_ff;
   assign rsp_elec_velocity = rsp_ev_ff;
   assign rsp_update_cause  = rsp_cause_ff;

`ifndef SYNTHESIS
   // An accepted beat starts the program, so the input stalls next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("input not stalled after request beat");

   // Every delivered result comes from a seeded estimate
   a_seeded_on_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> seeded_ff)
      else $error("result without seeded estimate");

   // A re-seed clears the velocity
   a_reseed_zero_vel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_update_cause != CAUSE_TRACKED)) |-> (rsp_mech_velocity == 0))
      else $error("re-seed result with nonzero velocity");

   // Loading the result returns the sequencer to idle
   a_out_to_idle: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (pc_ff == STEP_IDLE) && rsp_valid)
      else $error("sequencer did not return to idle after result");
`endif

endmodule
